// ===== hdl/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, codes and constants of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

  localparam int VALUE_W  = 64;
  localparam int MODE_W   = 2;
  localparam int CAP_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;
  localparam int NIB_W    = 4;

  localparam int DEF_MAX_HEX_DIGITS = 16;
  localparam int DEF_MAX_DEC_DIGITS = 20;

  // Bits consumed by the conversion unit per cycle.
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;

  localparam logic [MODE_W-1:0] MODE_HEX  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UDEC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SDEC = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_CAP  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic [CAP_W-1:0]   buffer_size;
  } in_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   out_char;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic negate;
    logic hex;
    logic step;
    logic shift;
  } du_ctrl_t;

endpackage

// ===== hdl/integer_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats a 64-bit value as hexadecimal, unsigned or signed decimal ASCII and
// streams the characters out, most significant first, ending with a NUL.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                     | Beat
//   --------+-----------------------------+---------------------------------
//   in      | in_valid, in_ready, in_data | mode, value, buffer_size
//   out     | out_valid, out_ready,       | out_char, last, status, length
//           | out_data                    |
//
// An item passes an accept step, the conversion steps of the shift-and-add-3
// unit and the stripping of leading zeros, and then gives one output beat per
// cycle while out_ready allows, prefix and terminator included.
// A zero capacity skips conversion and gives its single beat right away.
// in_ready is high only between items; out_ready low holds the output register
// and stalls the emission. Reset is synchronous and clears state and out_valid.
module integer_to_ascii_formatter_top #(
  parameter int MAX_HEX_DIGITS = ita_pkg::DEF_MAX_HEX_DIGITS,
  parameter int MAX_DEC_DIGITS = ita_pkg::DEF_MAX_DEC_DIGITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ita_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ita_pkg::out_beat_t out_data
);
  import ita_pkg::*;

  localparam int ND_W   = $clog2(MAX_DEC_DIGITS + 1);
  localparam int STEP_W = $clog2(CONV_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_FAIL = 3'd4;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d);
    if (d < NIB_W'(10)) begin
      return CH_ZERO + CHAR_W'(d);
    end
    return CH_A + CHAR_W'(d) - CHAR_W'(10);
  endfunction

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [STEP_W-1:0]   step_cnt;
  logic [STEP_W-1:0]   step_cnt_next;
  logic [ND_W-1:0]     nd;
  logic [ND_W-1:0]     nd_next;
  logic [1:0]          pre_cnt;
  logic [1:0]          pre_cnt_next;
  logic                hex;
  logic                hex_next;
  logic [CAP_W-1:0]    cap;
  logic [CAP_W-1:0]    cap_next;
  logic [CAP_W-1:0]    total;
  logic [CAP_W-1:0]    total_next;
  logic [STATUS_W-1:0] fail_status;
  logic [STATUS_W-1:0] fail_status_next;
  logic                out_valid_next;
  out_beat_t           out_beat;
  out_beat_t           out_beat_next;

  logic                slot_free;
  logic                neg;
  logic [CAP_W-1:0]    scan_total;
  logic [NIB_W-1:0]    top_digit;
  du_ctrl_t            du_ctrl;

  ita_digit_unit #(
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS),
    .MAX_DEC_DIGITS(MAX_DEC_DIGITS)
  ) u_digit_unit (
    .clk       (clk),
    .ctrl      (du_ctrl),
    .value     (in_data.value),
    .top_digit (top_digit)
  );

  assign in_ready   = (state == S_IDLE);
  assign slot_free  = !out_valid || out_ready;
  assign neg        = (in_data.mode != MODE_HEX) && (in_data.mode != MODE_UDEC)
                      && in_data.value[VALUE_W-1];
  assign scan_total = CAP_W'(pre_cnt) + CAP_W'(nd);

  always_comb begin
    state_next       = state;
    step_cnt_next    = step_cnt;
    nd_next          = nd;
    pre_cnt_next     = pre_cnt;
    hex_next         = hex;
    cap_next         = cap;
    total_next       = total;
    fail_status_next = fail_status;
    out_valid_next   = out_valid && !out_ready;
    out_beat_next    = out_beat;
    du_ctrl          = '0;
    du_ctrl.hex      = hex;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          du_ctrl.load   = 1'b1;
          du_ctrl.hex    = (in_data.mode == MODE_HEX);
          du_ctrl.negate = neg;
          hex_next       = (in_data.mode == MODE_HEX);
          cap_next       = in_data.buffer_size;
          step_cnt_next  = '0;
          nd_next        = ND_W'(MAX_DEC_DIGITS);
          pre_cnt_next   = (in_data.mode == MODE_HEX) ? 2'd2 : (neg ? 2'd1 : 2'd0);
          if (in_data.buffer_size == '0) begin
            fail_status_next = ST_ZERO_CAP;
            state_next       = S_FAIL;
          end else begin
            state_next = S_CONV;
          end
        end
      end
      S_CONV: begin
        du_ctrl.step  = 1'b1;
        step_cnt_next = step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(CONV_STEPS - 1)) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (nd > ND_W'(1) && top_digit == '0) begin
          du_ctrl.shift = 1'b1;
          nd_next       = nd - ND_W'(1);
        end else begin
          total_next = scan_total;
          if (cap <= scan_total) begin
            fail_status_next = ST_TOO_SMALL;
            state_next       = S_FAIL;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_next       = 1'b1;
          out_beat_next.last   = 1'b0;
          out_beat_next.status = ST_OK;
          out_beat_next.length = '0;
          if (pre_cnt != 2'd0) begin
            pre_cnt_next = pre_cnt - 2'd1;
            if (!hex) begin
              out_beat_next.out_char = CH_MINUS;
            end else if (pre_cnt == 2'd2) begin
              out_beat_next.out_char = CH_ZERO;
            end else begin
              out_beat_next.out_char = CH_X;
            end
          end else if (nd != '0) begin
            du_ctrl.shift          = 1'b1;
            nd_next                = nd - ND_W'(1);
            out_beat_next.out_char = digit_char(top_digit);
          end else begin
            out_beat_next.out_char = CH_NUL;
            out_beat_next.last     = 1'b1;
            out_beat_next.length   = total[LEN_W-1:0];
            state_next             = S_IDLE;
          end
        end
      end
      S_FAIL: begin
        if (slot_free) begin
          out_valid_next         = 1'b1;
          out_beat_next.out_char = CH_NUL;
          out_beat_next.last     = 1'b1;
          out_beat_next.status   = fail_status;
          out_beat_next.length   = '0;
          state_next             = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    step_cnt    <= step_cnt_next;
    nd          <= nd_next;
    pre_cnt     <= pre_cnt_next;
    hex         <= hex_next;
    cap         <= cap_next;
    total       <= total_next;
    fail_status <= fail_status_next;
    out_beat    <= out_beat_next;
  end

  assign out_data = out_beat;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted without leaving idle.");

  a_mid_beat_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> out_data.status == ST_OK && out_data.length == '0)
    else $error("Non-final beat carries status or length.");

  a_fail_no_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.last && out_data.length == '0)
    else $error("Failed run is not a single empty terminator.");

  a_last_is_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.out_char == CH_NUL)
    else $error("Final beat is not a terminator.");

  a_scan_keeps_digit: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> nd != '0)
    else $error("Leading zero strip removed every digit.");

endmodule

// ===== hdl/ita_digit_unit.sv =====
// ----------------------------------------------------------------------------
// ita_digit_unit
// Shift-and-add-3 converter that builds the digit string of the value four
// bits per cycle, then hands digits out from the top one at a time.
// ----------------------------------------------------------------------------
module ita_digit_unit #(
  parameter int MAX_HEX_DIGITS = ita_pkg::DEF_MAX_HEX_DIGITS,
  parameter int MAX_DEC_DIGITS = ita_pkg::DEF_MAX_DEC_DIGITS
) (
  input  logic                      clk,
  input  ita_pkg::du_ctrl_t         ctrl,
  input  logic [ita_pkg::VALUE_W-1:0] value,
  output logic [ita_pkg::NIB_W-1:0]   top_digit
);
  import ita_pkg::*;

  localparam int DIG_W   = NIB_W * MAX_DEC_DIGITS;
  localparam int HEX_BITS = NIB_W * MAX_HEX_DIGITS;
  localparam logic [VALUE_W-1:0] HEX_MASK = {VALUE_W{1'b1}} >> (VALUE_W - HEX_BITS);

  logic [VALUE_W-1:0] v;
  logic [VALUE_W-1:0] v_next;
  logic [DIG_W-1:0]   dig;
  logic [DIG_W-1:0]   dig_next;

  always_comb begin
    v_next   = v;
    dig_next = dig;
    if (ctrl.load) begin
      dig_next = '0;
      if (ctrl.hex) begin
        v_next = value & HEX_MASK;
      end else if (ctrl.negate) begin
        v_next = (~value) + VALUE_W'(1);
      end else begin
        v_next = value;
      end
    end else if (ctrl.step) begin
      for (int s = 0; s < BITS_PER_STEP; s++) begin
        if (!ctrl.hex) begin
          for (int k = 0; k < MAX_DEC_DIGITS; k++) begin
            if (dig_next[k*NIB_W +: NIB_W] >= NIB_W'(5)) begin
              dig_next[k*NIB_W +: NIB_W] = dig_next[k*NIB_W +: NIB_W] + NIB_W'(3);
            end
          end
        end
        dig_next = {dig_next[DIG_W-2:0], v_next[VALUE_W-1]};
        v_next   = {v_next[VALUE_W-2:0], 1'b0};
      end
    end else if (ctrl.shift) begin
      dig_next = {dig[DIG_W-NIB_W-1:0], {NIB_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    v   <= v_next;
    dig <= dig_next;
  end

  assign top_digit = dig[DIG_W-1 -: NIB_W];

endmodule

// ===== test/integer_to_ascii_formatter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top_tb
// Self-checking bench for the integer to ASCII formatter. A directed set covers
// the value, mode and capacity corners. Random values of mixed magnitude and
// sign follow, with capacities mostly placed right at the fit boundary. Each
// accepted input beat is turned into its expected character beats by a local
// formatter, and these are compared field by field with the output stream.
// Both sides idle at random, and the output side also holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top_tb;

  import ita_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int DEC_BASE   = 10;
  localparam int TEXT_CHARS = 24;
  localparam int ITEM_COUNT = 410;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  in_beat_t  pending_q[$];
  out_beat_t expected_chars_q[$];
  int        in_count   = 0;
  int        item_total = 0;
  int        fail_count = 0;
  logic      hold_off   = 1'b0;
  logic      steady;

  integer_to_ascii_formatter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign steady = (in_count >= 250) && (in_count < 330);

  // Builds the string without its terminator, first character in the lowest byte.
  function automatic int render_text(input logic [MODE_W-1:0] mode,
                                     input logic [VALUE_W-1:0] value,
                                     output logic [CHAR_W*TEXT_CHARS-1:0] text);
    logic [VALUE_W-1:0]          mag;
    logic [CHAR_W*TEXT_CHARS-1:0] digs;
    logic [NIB_W-1:0]            nib;
    int                          nd;
    int                          np;
    mag  = value;
    nd   = 0;
    np   = 0;
    text = '0;
    digs = '0;
    if (mode == MODE_HEX) begin
      text[0 +: CHAR_W]      = CH_ZERO;
      text[CHAR_W +: CHAR_W] = CH_X;
      np = 2;
      do begin
        nib = mag[NIB_W-1:0];
        digs[CHAR_W*nd +: CHAR_W] = (nib < DEC_BASE)
                                    ? CH_ZERO + CHAR_W'(nib)
                                    : CH_A + CHAR_W'(nib) - CHAR_W'(DEC_BASE);
        nd++;
        mag = mag >> NIB_W;
      end while (mag != 0 && nd < DEF_MAX_HEX_DIGITS);
    end else begin
      if (mode != MODE_UDEC && mag[VALUE_W-1]) begin
        text[0 +: CHAR_W] = CH_MINUS;
        np  = 1;
        mag = ~mag + 1'b1;
      end
      do begin
        digs[CHAR_W*nd +: CHAR_W] = CH_ZERO + CHAR_W'(mag % DEC_BASE);
        nd++;
        mag = mag / DEC_BASE;
      end while (mag != 0 && nd < DEF_MAX_DEC_DIGITS);
    end
    for (int i = 0; i < nd; i++) begin
      text[CHAR_W*(np+i) +: CHAR_W] = digs[CHAR_W*(nd-1-i) +: CHAR_W];
    end
    return np + nd;
  endfunction

  task automatic queue_formatted_string(input in_beat_t b);
    logic [CHAR_W*TEXT_CHARS-1:0] text;
    out_beat_t                    e;
    int                           n;
    e = '0;
    if (b.buffer_size == 0) begin
      e.out_char = CH_NUL;
      e.last     = 1'b1;
      e.status   = ST_ZERO_CAP;
      expected_chars_q.push_back(e);
    end else begin
      n = render_text(b.mode, b.value, text);
      if (int'(b.buffer_size) < n + 1) begin
        e.out_char = CH_NUL;
        e.last     = 1'b1;
        e.status   = ST_TOO_SMALL;
        expected_chars_q.push_back(e);
      end else begin
        e.status = ST_OK;
        for (int i = 0; i < n; i++) begin
          e.out_char = text[CHAR_W*i +: CHAR_W];
          expected_chars_q.push_back(e);
        end
        e.out_char = CH_NUL;
        e.last     = 1'b1;
        e.length   = LEN_W'(n);
        expected_chars_q.push_back(e);
      end
    end
  endtask

  task automatic add_item(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                          input logic [CAP_W-1:0] cap);
    in_beat_t b;
    b.mode        = mode;
    b.value       = value;
    b.buffer_size = cap;
    pending_q.push_back(b);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        queue_formatted_string(in_data);
        in_count <= in_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(99) >= 25)) begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars_q.size() == 0) begin
          $error("out beat with nothing expected: char %h", out_data.out_char);
          fail_count++;
        end else begin
          if (out_data.out_char !== expected_chars_q[0].out_char) begin
            $error("out_char: expected %h, actual %h",
                   expected_chars_q[0].out_char, out_data.out_char);
            fail_count++;
          end
          if (out_data.last !== expected_chars_q[0].last) begin
            $error("last: expected %b, actual %b", expected_chars_q[0].last, out_data.last);
            fail_count++;
          end
          if (out_data.status !== expected_chars_q[0].status) begin
            $error("status: expected %0d, actual %0d",
                   expected_chars_q[0].status, out_data.status);
            fail_count++;
          end
          if (out_data.length !== expected_chars_q[0].length) begin
            $error("length: expected %0d, actual %0d",
                   expected_chars_q[0].length, out_data.length);
            fail_count++;
          end
          void'(expected_chars_q.pop_front());
        end
      end
      out_ready <= !hold_off && (steady || $urandom_range(99) >= 25);
    end
  end

  // The output side stays closed long enough for the block to back up its input.
  initial begin
    wait (in_count >= 120);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("integer_to_ascii_formatter_top: mismatch");
    $finish;
  end

  initial begin
    logic [CHAR_W*TEXT_CHARS-1:0] scratch;
    logic [MODE_W-1:0]            mode;
    logic [VALUE_W-1:0]           raw;
    logic [VALUE_W-1:0]           value;
    logic [CAP_W-1:0]             cap;
    int                           n;

    add_item(MODE_HEX,  64'd0, 8'd4);
    add_item(MODE_HEX,  64'd0, 8'd3);
    add_item(MODE_HEX,  '1, 8'd19);
    add_item(MODE_HEX,  '1, 8'd18);
    add_item(MODE_HEX,  64'h0123_4567_89ab_cdef, 8'd255);
    add_item(MODE_HEX,  64'd5, 8'd0);
    add_item(MODE_UDEC, 64'd0, 8'd2);
    add_item(MODE_UDEC, '1, 8'd21);
    add_item(MODE_UDEC, '1, 8'd20);
    add_item(MODE_UDEC, 64'd1234567890, 8'd11);
    add_item(MODE_UDEC, 64'd10_000_000_000_000_000_000, 8'd255);
    add_item(MODE_UDEC, 64'd9, 8'd0);
    add_item(MODE_SDEC, 64'h8000_0000_0000_0000, 8'd21);
    add_item(MODE_SDEC, 64'h8000_0000_0000_0000, 8'd20);
    add_item(MODE_SDEC, '1, 8'd3);
    add_item(MODE_SDEC, 64'h7fff_ffff_ffff_ffff, 8'd255);
    add_item(MODE_SDEC, 64'd0, 8'd1);
    add_item(MODE_SDEC, 64'd0, 8'd2);
    add_item(MODE_SDEC, '1, 8'd0);
    add_item(MODE_SPARE, 64'hffff_ffff_ffff_ff85, 8'd5);
    add_item(MODE_SPARE, 64'd42, 8'd3);
    add_item(MODE_SPARE, 64'd7, 8'd0);

    while (pending_q.size() < ITEM_COUNT) begin
      case ($urandom_range(9))
        0, 1, 2: mode = MODE_HEX;
        3, 4, 5: mode = MODE_UDEC;
        6, 7, 8: mode = MODE_SDEC;
        default: mode = MODE_SPARE;
      endcase
      raw = {$urandom(), $urandom()};
      case ($urandom_range(5))
        0, 1:    value = raw;
        2:       value = raw >> $urandom_range(VALUE_W - 1);
        3:       value = ~(raw >> $urandom_range(VALUE_W - 1));
        4:       value = VALUE_W'($urandom_range(2 * DEC_BASE));
        default: value = raw >> $urandom_range(VALUE_W - 8, VALUE_W - 1);
      endcase
      n = render_text(mode, value, scratch);
      case ($urandom_range(9))
        0, 1, 2: cap = CAP_W'(n + 1);
        3, 4:    cap = CAP_W'(n);
        5, 6:    cap = CAP_W'(n + 1 + $urandom_range(3));
        7:       cap = 8'd0;
        default: cap = CAP_W'($urandom_range(255));
      endcase
      add_item(mode, value, cap);
    end
    item_total = pending_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (in_count == item_total);
    while (expected_chars_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("integer_to_ascii_formatter_top: match");
    end else begin
      $display("integer_to_ascii_formatter_top: mismatch");
    end
    $finish;
  end

endmodule
